@@ design/sihd_pkg.sv @@
// Shared types and constants for the source identity hash and dedup block.
package sihd_pkg;

  localparam logic [63:0] BASIS_HIGH = 64'd14695981039346656037;
  localparam logic [63:0] BASIS_LOW  = 64'd7809847782465536322;
  localparam logic [63:0] TAG_WORD   = 64'h43454c4c45524131;
  localparam logic [63:0] GOLDEN     = 64'h9e3779b97f4a7c15;

  // FNV 64 prime is 2^40 + 0x1b3
  localparam int          FNV_PRIME_SHIFT = 40;
  localparam logic [8:0]  FNV_PRIME_LOW   = 9'h1b3;

  localparam int          HASH_WORDS = 6;
  localparam int          HASH_STEPS = HASH_WORDS * 8;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_INCOMPLETE = 3'd1,
    STAT_DUPLICATE  = 3'd2,
    STAT_FAILED     = 3'd3,
    STAT_FULL       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_SEARCH
  } state_t;

  typedef struct packed {
    logic        start_batch;
    logic [63:0] owner_word;
    logic [63:0] file_word;
    logic [63:0] offset_word;
    logic [63:0] decl_word;
    logic [63:0] rev_word;
    logic        node_valid;
  } in_item_t;

  typedef struct packed {
    logic [63:0] identity_high;
    logic [63:0] identity_low;
    status_t     status;
  } out_item_t;

  // one FNV-1a byte step
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << FNV_PRIME_SHIFT) + (x * 64'(FNV_PRIME_LOW));
  endfunction

endpackage

@@ design/sihd_fnv.sv @@
// Two-lane FNV-1a 64 hash unit, one byte per lane per cycle.
module sihd_fnv
  import sihd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  in_item_t    item,
  output logic        done,
  output logic [63:0] hash_high,
  output logic [63:0] hash_low
);

  localparam int STEP_W = $clog2(HASH_STEPS);

  logic [HASH_WORDS*64-1:0] sr_r, sr_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic                     run_r, run_nxt;
  logic                     done_r, done_nxt;
  logic [63:0]              hi_r, hi_nxt;
  logic [63:0]              lo_r, lo_nxt;
  logic [7:0]               gbyte;
  logic                     last;

  assign gbyte = 8'(GOLDEN >> {step_r[2:0], 3'b000});
  assign last  = (step_r == STEP_W'(HASH_STEPS - 1));

  always_comb begin
    sr_nxt   = sr_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (load) begin
      sr_nxt   = {item.rev_word, item.decl_word, item.offset_word,
                  item.file_word, item.owner_word, TAG_WORD};
      step_nxt = '0;
      run_nxt  = 1'b1;
      hi_nxt   = BASIS_HIGH;
      lo_nxt   = BASIS_LOW;
    end else if (run_r) begin
      hi_nxt   = fnv_step(hi_r, sr_r[7:0]);
      lo_nxt   = fnv_step(lo_r, sr_r[7:0] ^ gbyte);
      sr_nxt   = sr_r >> 8;
      step_nxt = step_r + STEP_W'(1);
      if (last) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign done      = done_r;
  assign hash_high = hi_r;
  // all-zero identity is reserved
  assign hash_low  = ((hi_r | lo_r) == 64'd0) ? 64'd1 : lo_r;

endmodule

@@ design/source_identity_hash_dedup.sv @@
// Top level: item check, identity hash and duplicate search over the seen table.
//
// An item is taken when start is high and busy is low; one result follows as a
// one-cycle out_valid strobe that cannot be held off. An item that fails the
// batch or completeness check returns in the cycle after it is taken. Any other
// item is hashed and then searched against the N identities stored in the
// current batch (at most SEEN_DEPTH): the byte-serial FNV lanes take its 48 bytes,
// then one read a cycle through the seen memory, which has a single port and a
// registered read. busy stays high until the result is out; start_batch
// empties the table and clears the failed flag before its item is handled.
module source_identity_hash_dedup
  import sihd_pkg::*;
#(
  parameter int SEEN_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(SEEN_DEPTH + 1);
  localparam int IDX_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;

  state_t            state_r, state_nxt;
  logic              failed_r, failed_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [63:0]       id_hi_r, id_hi_nxt;
  logic [63:0]       id_lo_r, id_lo_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [127:0]      seen_mem [SEEN_DEPTH];
  logic [127:0]      rd_q_r;
  logic              rd_en, wr_en;
  logic              hash_load, hash_done;
  logic [63:0]       hash_high, hash_low;
  logic              incomplete;
  logic              match;

  sihd_fnv u_fnv (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (hash_load),
    .item      (in_data),
    .done      (hash_done),
    .hash_high (hash_high),
    .hash_low  (hash_low)
  );

  assign busy       = (state_r != S_IDLE);
  assign incomplete = (in_data.owner_word == 64'd0) || (in_data.file_word == 64'd0) ||
                      (in_data.decl_word == 64'd0) ||
                      (in_data.rev_word == 64'd0) || !in_data.node_valid;
  assign match      = pend_r && (rd_q_r == {id_hi_r, id_lo_r});

  always_comb begin
    state_nxt     = state_r;
    failed_nxt    = failed_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    id_hi_nxt     = id_hi_r;
    id_lo_nxt     = id_lo_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    hash_load     = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_data_nxt.identity_high = 64'd0;
          out_data_nxt.identity_low  = 64'd0;
          if (in_data.start_batch) begin
            count_nxt  = '0;
            failed_nxt = 1'b0;
          end
          priority if (failed_r && !in_data.start_batch) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = STAT_FAILED;
          end else if (incomplete) begin
            failed_nxt          = 1'b1;
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = STAT_INCOMPLETE;
          end else begin
            hash_load = 1'b1;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          id_hi_nxt = hash_high;
          id_lo_nxt = hash_low;
          idx_nxt   = '0;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        rd_en = (idx_r < count_r);
        if (rd_en) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        pend_nxt = rd_en;
        out_data_nxt.identity_high = id_hi_r;
        out_data_nxt.identity_low  = id_lo_r;
        if (match) begin
          pend_nxt            = 1'b0;
          failed_nxt          = 1'b1;
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = STAT_DUPLICATE;
          state_nxt           = S_IDLE;
        end else if (!rd_en) begin
          // last compare (if any) missed: the identity is new
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (count_r == CNT_W'(SEEN_DEPTH)) begin
            failed_nxt          = 1'b1;
            out_data_nxt.status = STAT_FULL;
          end else begin
            wr_en               = 1'b1;
            count_nxt           = count_r + CNT_W'(1);
            out_data_nxt.status = STAT_OK;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      failed_r    <= 1'b0;
      count_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      failed_r    <= failed_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_hi_r    <= id_hi_nxt;
    id_lo_r    <= id_lo_nxt;
    out_data_r <= out_data_nxt;
  end

  // seen table: one port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      seen_mem[count_r[IDX_W-1:0]] <= {id_hi_r, id_lo_r};
    end else if (rd_en) begin
      rd_q_r <= seen_mem[idx_r[IDX_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_failed_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && failed_r && !in_data.start_batch) |=>
      (out_valid && out_data.status == STAT_FAILED))
    else $error("failed batch item not answered at once");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SEEN_DEPTH))
    else $error("seen count beyond table depth");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STAT_DUPLICATE || out_data.status == STAT_FULL ||
                   out_data.status == STAT_INCOMPLETE)) |-> failed_r)
    else $error("error result without failed flag");

  a_count_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r) &&
     !$past(start && !busy && in_data.start_batch)) |->
      (out_valid && out_data.status == STAT_OK))
    else $error("table grew without an ok result");

  a_no_result_hashing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HASH) |=> !out_valid)
    else $error("result transfer during hashing");

endmodule
